FILE: rtl/rfcd_pkg.sv
// Shared types and constants for the region frame change detector.
// Used by region_frame_change_detector; no dependencies.
package rfcd_pkg;

  localparam int MAX_DIM_DEF    = 2048;
  localparam int SCORE_BITS_DEF = 16;
  localparam int CNT_W          = 22;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TITLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXTHR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATTHR  = 3'd4;

  localparam logic [1:0] TRIG_NONE    = 2'd0;
  localparam logic [1:0] TRIG_PAGE    = 2'd1;
  localparam logic [1:0] TRIG_TITLE   = 2'd2;
  localparam logic [1:0] TRIG_CONTENT = 2'd3;

  typedef struct packed {
    logic [10:0] pix_x;
    logic [10:0] pix_y;
    logic [7:0]  prev_b;
    logic [7:0]  prev_g;
    logic [7:0]  prev_r;
    logic [7:0]  curr_b;
    logic [7:0]  curr_g;
    logic [7:0]  curr_r;
    logic        frame_end;
  } pix_t;

  typedef struct packed {
    logic        changed;
    logic [1:0]  trigger;
    logic [16:0] score;
  } res_t;

endpackage

FILE: rtl/rfcd_if.sv
// Valid/ready stream interface carrying one payload of type T.
// Depends on nothing; payload types come from rfcd_pkg at the instance.
interface rfcd_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/region_frame_change_detector.sv
// Region frame change detector: counts changed pixel pairs per box and,
// at frame end, scores the boxes. Depends on rfcd_pkg and rfcd_if.
//
// Usage: pixel pairs enter on in_ch (valid/ready transfer). A pair that is
// not the last of a frame is counted in the counting stage and the block
// stays ready for the next pair. The pair with frame_end set starts a
// sequencer that scores page, title and the four content quadrants with one
// shared restoring divider (one quotient bit per cycle, CNT_W + SCORE_BITS
// bits per box plus a load and an accumulate state); in_ch is not ready
// until the sequencer is back in its run state, when the result becomes
// valid on out_ch. The single result then sits in an output register on
// out_ch until taken; the next frame's pairs are accepted while it waits,
// and a new frame end waits for the register to drain. Counts clear when
// the result is loaded. Configuration is written on the cfg_ port; the user
// must write it only while idle, as the block does not enforce this. Reset
// (rst_n low, synchronous) restores default thresholds, clears boxes and
// counts and empties the output register.
module region_frame_change_detector #(
  parameter int MAX_DIM    = rfcd_pkg::MAX_DIM_DEF,
  parameter int SCORE_BITS = rfcd_pkg::SCORE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rfcd_if.sink                            in_ch,
  rfcd_if.source                          out_ch,
  input  logic                            cfg_we,
  input  logic [rfcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rfcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = rfcd_pkg::CNT_W;
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int AW  = 2 * DW;
  localparam int NW  = CW + SCORE_BITS;         // dividend width
  localparam int QW  = SCORE_BITS + 1;          // capped score
  localparam int SW  = QW + 2;                  // sum of four scores
  localparam int ITW = $clog2(NW + 1);
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [5:0] {
    S_RUN  = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_ACC  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [DW-1:0] l, t, r, b;
    logic          on;
  } box_t;

  function automatic logic [DW-1:0] clampd(input logic [11:0] v);
    return (32'(v) > MAX_DIM) ? DW'(MAX_DIM) : DW'(v);
  endfunction

  function automatic box_t unpack(input logic [47:0] v);
    box_t bx;
    bx.on = (v[11:0] != v[35:24]) || (v[23:12] != v[47:36]);
    bx.l  = clampd(v[11:0]);
    bx.t  = clampd(v[23:12]);
    bx.r  = clampd(v[35:24]);
    bx.b  = clampd(v[47:36]);
    return bx;
  endfunction

  function automatic logic inbox(input logic [DW-1:0] x, y, l, t, r, b);
    return x >= l && x < r && y >= t && y < b;
  endfunction

  logic [47:0] title_r, content_r, page_r;
  logic [7:0]  pthr_r;
  logic [15:0] rthr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      title_r   <= '0;
      content_r <= '0;
      page_r    <= '0;
      pthr_r    <= 8'd30;
      rthr_r    <= 16'd3277;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rfcd_pkg::REG_TITLE:   title_r   <= cfg_data;
        rfcd_pkg::REG_CONTENT: content_r <= cfg_data;
        rfcd_pkg::REG_PAGE:    page_r    <= cfg_data;
        rfcd_pkg::REG_PIXTHR:  pthr_r    <= cfg_data[7:0];
        rfcd_pkg::REG_RATTHR:  rthr_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  box_t pg, ti, co;
  logic cvalid;
  logic [DW-1:0] mx, my;
  always_comb begin
    pg = unpack(page_r);
    ti = unpack(title_r);
    co = unpack(content_r);
    cvalid = co.r > co.l && co.b > co.t;
    mx = cvalid ? DW'(co.l + ((co.r - co.l) >> 1)) : '0;
    my = cvalid ? DW'(co.t + ((co.b - co.t) >> 1)) : '0;
  end

  // rescale the Q0.16 threshold to Q0.SCORE_BITS
  logic [QW-1:0] thr;
  always_comb begin
    thr = QW'({rthr_r, 8'h00} >> (24 - SCORE_BITS));
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r [6];
  logic [2:0]    sel_r;          // 0 page, 1 title, 2..5 quadrants
  logic [NW-1:0] rem_r, quo_r;
  logic [AW-1:0] den_r;
  logic [ITW-1:0] it_r;
  logic [SW-1:0] sum_r;
  logic [1:0]    trig_r;
  logic [QW-1:0] sc_r;
  rfcd_pkg::res_t res_r;
  logic          ovld_r;

  // pixel stage
  rfcd_pkg::pix_t px;
  logic [7:0] db, dg, dr, gray;
  logic [DW-1:0] xx, yy;
  logic hit;
  logic [5:0] inc;
  always_comb begin
    px = in_ch.data;
    db = px.prev_b > px.curr_b ? px.prev_b - px.curr_b : px.curr_b - px.prev_b;
    dg = px.prev_g > px.curr_g ? px.prev_g - px.curr_g : px.curr_g - px.prev_g;
    dr = px.prev_r > px.curr_r ? px.prev_r - px.curr_r : px.curr_r - px.prev_r;
    gray = 8'((27'(4899) * dr + 27'(9617) * dg + 27'(1868) * db + 27'(8192)) >> 14);
    xx = DW'(px.pix_x);
    yy = DW'(px.pix_y);
    hit = gray > pthr_r && 32'(px.pix_x) < MAX_DIM && 32'(px.pix_y) < MAX_DIM;
    inc[0] = hit && inbox(xx, yy, pg.l, pg.t, pg.r, pg.b);
    inc[1] = hit && inbox(xx, yy, ti.l, ti.t, ti.r, ti.b);
    inc[2] = hit && cvalid && inbox(xx, yy, co.l, co.t, mx, my);
    inc[3] = hit && cvalid && inbox(xx, yy, mx, co.t, co.r, my);
    inc[4] = hit && cvalid && inbox(xx, yy, co.l, my, mx, co.b);
    inc[5] = hit && cvalid && inbox(xx, yy, mx, my, co.r, co.b);
  end

  // area and enable of the box under evaluation
  logic [DW-1:0] al, at, ar, ab;
  logic ben;
  always_comb begin
    al = co.l; at = co.t; ar = co.r; ab = co.b; ben = co.on;
    case (sel_r)
      3'd0: begin al = pg.l; at = pg.t; ar = pg.r; ab = pg.b; ben = pg.on; end
      3'd1: begin al = ti.l; at = ti.t; ar = ti.r; ab = ti.b; ben = ti.on; end
      3'd2: begin ar = mx; ab = my; end
      3'd3: begin al = mx; ab = my; end
      3'd4: begin at = my; ar = mx; end
      3'd5: begin al = mx; at = my; end
      default: ;
    endcase
  end
  logic [AW-1:0] area;
  assign area = (ar <= al || ab <= at) ? '0 : AW'(ar - al) * AW'(ab - at);

  // shared divider step
  logic [NW:0] trial;
  assign trial = {rem_r, quo_r[NW-1]} - {{(NW + 1 - AW){1'b0}}, den_r};

  logic [QW-1:0] qcap;
  assign qcap = (den_r == '0) ? '0 :
                (quo_r > NW'(1 << SCORE_BITS)) ? QW'(1 << SCORE_BITS) : QW'(quo_r);

  logic in_fire, last_fire;
  assign in_ch.ready = (state_r == S_RUN) &&
                       !(in_ch.data.frame_end && ovld_r);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign last_fire = in_fire && in_ch.data.frame_end;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RUN:  if (last_fire) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (it_r == ITW'(NW - 1)) state_nxt = S_ACC;
      S_ACC: begin
        if (sel_r == 3'd5) state_nxt = S_FIN;
        else               state_nxt = S_LOAD;
      end
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_RUN;
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      sel_r   <= '0;
      trig_r  <= rfcd_pkg::TRIG_NONE;
      sum_r   <= '0;
      sc_r    <= '0;
      ovld_r  <= 1'b0;
      it_r    <= '0;
      for (int i = 0; i < 6; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) ovld_r <= 1'b0;
      unique case (state_r)
        S_RUN: begin
          if (in_fire) begin
            for (int i = 0; i < 6; i++)
              if (inc[i] && cnt_r[i] != CNT_MAX) cnt_r[i] <= cnt_r[i] + 1'b1;
          end
          sel_r  <= '0;
          trig_r <= rfcd_pkg::TRIG_NONE;
          sum_r  <= '0;
          sc_r   <= '0;
        end
        S_LOAD: begin
          rem_r <= '0;
          quo_r <= {cnt_r[sel_r], {SCORE_BITS{1'b0}}};
          den_r <= area;
          it_r  <= '0;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!trial[NW] && den_r != '0) begin
            rem_r <= trial[NW-1:0];
            quo_r <= {quo_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[NW-2:0], quo_r[NW-1]};
            quo_r <= {quo_r[NW-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
        end
        S_ACC: begin
          sel_r <= sel_r + 1'b1;
          if (sel_r < 3'd2) begin
            if (trig_r == rfcd_pkg::TRIG_NONE && ben && qcap > thr) begin
              trig_r <= (sel_r == 3'd0) ? rfcd_pkg::TRIG_PAGE : rfcd_pkg::TRIG_TITLE;
              sc_r   <= qcap;
            end
          end else if (cvalid && qcap > thr) begin
            sum_r <= sum_r + SW'(qcap);
          end
        end
        S_FIN: begin
          if (trig_r == rfcd_pkg::TRIG_NONE && co.on && sum_r > (SW'(thr) << 2)) begin
            trig_r <= rfcd_pkg::TRIG_CONTENT;
            sc_r   <= QW'(sum_r >> 2);
          end
        end
        S_OUT: begin
          ovld_r <= 1'b1;
          for (int i = 0; i < 6; i++) cnt_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      res_r.changed <= trig_r != rfcd_pkg::TRIG_NONE;
      res_r.trigger <= trig_r;
      res_r.score   <= 17'(sc_r);
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.data  = res_r;

endmodule
